### rtl/assert_macros.svh
// Assertion macros shared by the command line mode controller RTL.
// Standalone header; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/clmc_pkg.sv
// Package for the command line mode controller: beat types, codes, constants.
// No dependencies; imported by the top level, clmc_line_asm and clmc_cmd_exec.
`timescale 1ns / 1ps

package clmc_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [1:0] mode_now;
    logic [6:0] speed_val;
    logic [1:0] drive_dir;
  } out_beat_t;

  typedef enum logic [2:0] {
    EV_STOP      = 3'd0,
    EV_MANUAL    = 3'd1,
    EV_AUTO      = 3'd2,
    EV_SPEED     = 3'd3,
    EV_DRIVE     = 3'd4,
    EV_HEARTBEAT = 3'd5,
    EV_IGNORED   = 3'd6,
    EV_LINK_LOST = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    MD_IDLE   = 2'd0,
    MD_MANUAL = 2'd1,
    MD_AUTO   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    DIR_F = 2'd0,
    DIR_B = 2'd1,
    DIR_L = 2'd2,
    DIR_R = 2'd3
  } dir_t;

  // Completed line, handed from the line assembler to the executor.
  typedef struct packed {
    logic       done;
    logic [7:0] letter;
    logic [6:0] number;
  } line_end_t;

  localparam int unsigned APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_LINK_TIMEOUT = 2'd0;

  localparam logic [15:0] TIMEOUT_RESET = 16'd150;
  localparam logic [6:0]  NUM_CLAMP     = 7'd100;
  localparam logic [6:0]  NUM_SAT       = 7'd101;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [7:0] CMD_STOP      = 8'h53; // S
  localparam logic [7:0] CMD_MANUAL    = 8'h4D; // M
  localparam logic [7:0] CMD_AUTO      = 8'h41; // A
  localparam logic [7:0] CMD_SPEED     = 8'h56; // V
  localparam logic [7:0] CMD_FWD       = 8'h46; // F
  localparam logic [7:0] CMD_BACK      = 8'h42; // B
  localparam logic [7:0] CMD_LEFT      = 8'h4C; // L
  localparam logic [7:0] CMD_RIGHT     = 8'h52; // R
  localparam logic [7:0] CMD_HEARTBEAT = 8'h48; // H

endpackage

### rtl/clmc_chan_if.sv
// Valid/ready channel interface carrying one payload beat.
// Payload type is a parameter.
`timescale 1ns / 1ps

interface clmc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/command_line_mode_controller.sv
// Top level of the command line mode controller: channel registers, APB register
// and the two processing parts. Depends on clmc_pkg, clmc_chan_if, clmc_line_asm, clmc_cmd_exec.
`timescale 1ns / 1ps

// Command line mode controller. Each input beat is either one received byte
// (action 0) or one control tick (action 1). Bytes build a command line that
// ends at CR or LF; only the first LINE_CHARS_MAX bytes of a line are kept and
// empty lines produce nothing. On the line end, the first letter picks the
// command (S stop, M manual, A auto, V speed, F/B/L/R drive in manual mode,
// H heartbeat, anything else ignored) and the number after it, parsed as a
// signed decimal with leading white space, is clamped to 0..100. Every handled
// line stamps the current tick count; in auto mode a tick whose distance from
// that stamp exceeds link_timeout_ticks (APB address 0, reset 150) drops the
// mode to idle and emits a link-lost beat. A beat yields zero or one result
// beat. Throughput is one beat per clock unless the output stalls: a beat is
// held in the input register, processed by combinational logic, and its result
// is loaded into the output register. The held beat advances only when the
// output register is empty or its result is taken in the same cycle, so a
// waiting result holds the input register; output backpressure is the only
// thing that stalls the input.
// Program the timeout only while no beats are in flight.
module command_line_mode_controller
  import clmc_pkg::*;
#(
  parameter int unsigned LINE_CHARS_MAX = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  clmc_chan_if.sink             in_ch,
  clmc_chan_if.source           out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Input register: holds one accepted beat until the output side can take it.
  logic     in_valid_r, in_valid_nxt;
  in_beat_t in_beat_r, in_beat_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_beat_r, out_beat_nxt;

  // Timeout register.
  logic [15:0] timeout_r, timeout_nxt;

  logic      out_free;
  logic      step;
  logic      cfg_wr;
  line_end_t line_end;
  logic      res_valid;
  out_beat_t res;

  // Advance the held beat whenever the output register is empty or drains.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_beat_nxt  = in_beat_r;
    if (in_ch.ready) begin
      in_valid_nxt = in_ch.valid;
      in_beat_nxt  = in_ch.payload;
    end
  end

  // Load a result only when the step produced one; otherwise drop valid once drained.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (out_free) begin
      out_valid_nxt = step && res_valid;
      if (step && res_valid) begin
        out_beat_nxt = res;
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_beat_r;

  // APB register access: write in the access phase, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_LINK_TIMEOUT);
  assign prdata = (paddr == ADDR_LINK_TIMEOUT) ? {16'd0, timeout_r} : '0;

  always_comb begin
    timeout_nxt = timeout_r;
    if (cfg_wr) begin
      timeout_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      timeout_r   <= timeout_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    in_beat_r  <= in_beat_nxt;
    out_beat_r <= out_beat_nxt;
  end

  clmc_line_asm #(
    .LINE_CHARS_MAX(LINE_CHARS_MAX)
  ) u_line_asm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .beat    (in_beat_r),
    .line_end(line_end)
  );

  clmc_cmd_exec u_cmd_exec (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .is_tick     (in_beat_r.action),
    .line_end    (line_end),
    .link_timeout(timeout_r),
    .res_valid   (res_valid),
    .res         (res)
  );

endmodule

### rtl/clmc_line_asm.sv
// Line assembler: collects bytes into a command line, keeps the command letter
// and parses the number on the fly. Depends on clmc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clmc_line_asm
  import clmc_pkg::*;
#(
  parameter int unsigned LINE_CHARS_MAX = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_beat_t  beat,
  output line_end_t line_end
);

  localparam int unsigned LEN_W = $clog2(LINE_CHARS_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CHARS_MAX);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       letter_r, letter_nxt;
  phase_t           phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [6:0]       acc_r, acc_nxt;

  logic [7:0]  c;
  logic        is_eol;
  logic        is_digit;
  logic        is_space;
  logic [3:0]  dval;
  logic [10:0] sum;
  logic [6:0]  acc_fed;

  assign c        = beat.rx_byte;
  assign is_eol   = (c == CH_LF) || (c == CH_CR);
  assign is_digit = (c >= CH_0) && (c <= CH_9);
  assign is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  assign dval     = 4'(c - CH_0);
  assign sum      = 11'(acc_r) * 11'd10 + 11'(dval);
  assign acc_fed  = (sum > 11'(NUM_SAT)) ? NUM_SAT : 7'(sum);

  always_comb begin
    len_nxt    = len_r;
    letter_nxt = letter_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    if (step && !beat.action) begin
      if (is_eol) begin
        len_nxt    = '0;
        letter_nxt = '0;
        phase_nxt  = PH_SKIP;
        neg_nxt    = 1'b0;
        acc_nxt    = '0;
      end else if (len_r < LEN_MAX) begin
        len_nxt = len_r + 1'b1;
        if (len_r == '0) begin
          letter_nxt = c;
        end else begin
          unique case (phase_r)
            PH_SKIP: begin
              priority if (is_space) begin
                phase_nxt = PH_SKIP;
              end else if (c == CH_PLUS) begin
                phase_nxt = PH_SIGN;
              end else if (c == CH_MINUS) begin
                neg_nxt   = 1'b1;
                phase_nxt = PH_SIGN;
              end else if (is_digit) begin
                acc_nxt   = acc_fed;
                phase_nxt = PH_DIGITS;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            PH_SIGN, PH_DIGITS: begin
              if (is_digit) begin
                acc_nxt   = acc_fed;
                phase_nxt = PH_DIGITS;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            default: phase_nxt = phase_r;
          endcase
        end
      end
    end
  end

  assign line_end.done   = step && !beat.action && is_eol && (len_r != '0);
  assign line_end.letter = letter_r;
  assign line_end.number = neg_r ? '0 : ((acc_r > NUM_CLAMP) ? NUM_CLAMP : acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      letter_r <= '0;
      phase_r  <= PH_SKIP;
      neg_r    <= 1'b0;
      acc_r    <= '0;
    end else begin
      len_r    <= len_nxt;
      letter_r <= letter_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      acc_r    <= acc_nxt;
    end
  end

  `CLMC_ASSERT_NOW(a_len_bounded, clk, rst_n, 1'b1, len_r <= LEN_MAX, "line length past max")
  `CLMC_ASSERT_NOW(a_acc_sat, clk, rst_n, 1'b1, acc_r <= NUM_SAT, "accumulator past saturation")

endmodule

### rtl/clmc_cmd_exec.sv
// Command executor: mode register, tick counter, last-command stamp and the
// per-beat event decode. Depends on clmc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clmc_cmd_exec
  import clmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        is_tick,
  input  line_end_t   line_end,
  input  logic [15:0] link_timeout,
  output logic        res_valid,
  output out_beat_t   res
);

  mode_t       mode_r, mode_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] stamp_r, stamp_nxt;

  logic [31:0] tick_inc;
  logic [31:0] gap;
  logic        timed_out;

  assign tick_inc  = tick_r + 32'd1;
  assign gap       = tick_inc - stamp_r;
  assign timed_out = gap > {16'd0, link_timeout};

  always_comb begin
    mode_nxt      = mode_r;
    tick_nxt      = tick_r;
    stamp_nxt     = stamp_r;
    res_valid     = 1'b0;
    res.event_res = EV_IGNORED;
    res.speed_val = '0;
    res.drive_dir = DIR_F;
    if (step && is_tick) begin
      tick_nxt = tick_inc;
      if ((mode_r == MD_AUTO) && timed_out) begin
        mode_nxt      = MD_IDLE;
        res_valid     = 1'b1;
        res.event_res = EV_LINK_LOST;
      end
    end else if (line_end.done) begin
      stamp_nxt = tick_r;
      res_valid = 1'b1;
      unique case (line_end.letter)
        CMD_STOP: begin
          mode_nxt      = MD_IDLE;
          res.event_res = EV_STOP;
        end
        CMD_MANUAL: begin
          mode_nxt      = MD_MANUAL;
          res.event_res = EV_MANUAL;
        end
        CMD_AUTO: begin
          mode_nxt      = MD_AUTO;
          res.event_res = EV_AUTO;
        end
        CMD_SPEED: begin
          res.event_res = EV_SPEED;
          res.speed_val = line_end.number;
        end
        CMD_FWD, CMD_BACK, CMD_LEFT, CMD_RIGHT: begin
          if (mode_r == MD_MANUAL) begin
            res.event_res = EV_DRIVE;
            res.speed_val = line_end.number;
            priority if (line_end.letter == CMD_FWD) begin
              res.drive_dir = DIR_F;
            end else if (line_end.letter == CMD_BACK) begin
              res.drive_dir = DIR_B;
            end else if (line_end.letter == CMD_LEFT) begin
              res.drive_dir = DIR_L;
            end else begin
              res.drive_dir = DIR_R;
            end
          end
        end
        CMD_HEARTBEAT: res.event_res = EV_HEARTBEAT;
        default:       res.event_res = EV_IGNORED;
      endcase
    end
    res.mode_now = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MD_IDLE;
      tick_r  <= '0;
      stamp_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      tick_r  <= tick_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  `CLMC_ASSERT_NOW(a_lost_from_auto, clk, rst_n,
                   res_valid && (res.event_res == EV_LINK_LOST), mode_r == MD_AUTO,
                   "link lost outside auto")
  `CLMC_ASSERT_NEXT(a_lost_goes_idle, clk, rst_n,
                    res_valid && (res.event_res == EV_LINK_LOST), mode_r == MD_IDLE,
                    "mode not idle after link lost")
  `CLMC_ASSERT_NOW(a_drive_in_manual, clk, rst_n,
                   res_valid && (res.event_res == EV_DRIVE), mode_r == MD_MANUAL,
                   "drive outside manual")

endmodule
